// ----- src/wgrg_pkg.sv -----
package wgrg_pkg;

  typedef logic [7:0] speed_t;
  typedef logic [4:0] holdoff_t;
  typedef logic [0:0] cfg_index_t;

  localparam speed_t     SPEED_MAX           = 8'd200;
  localparam holdoff_t   HOLDOFF_PERIOD      = 5'd30;
  localparam holdoff_t   HOLDOFF_MAX         = 5'd31;

  localparam cfg_index_t REG_FOLD_THRESHOLD  = 1'b0;
  localparam cfg_index_t REG_USED_AS_SHUTTER = 1'b1;

  typedef struct packed {
    logic   advance;
    speed_t threshold;
  } cell_ctrl_t;

endpackage

// ----- src/wgrg_cell.sv -----
module wgrg_cell
  import wgrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  speed_t     speed_in,
  input  logic       above_in,
  output speed_t     speed_out,
  output logic       above_out
);

  speed_t speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (ctrl.advance) begin
      speed <= speed_in;
    end
  end

  // compare the entry this cell takes on the current transfer
  assign above_out = above_in & (speed_in > ctrl.threshold);
  assign speed_out = speed;

endmodule

// ----- src/wind_gust_retract_guard.sv -----
// Wind gust retract guard. Each input transfer is one tick carrying the
// anemometer pulse count and the sensor input level; each tick yields
// exactly one registered result: speed in km/h (pulses halved,
// capped at 200), the retract command pulse, the all-above flag and the
// registered input level. The speed window is a row of WINDOW_LEN cells
// that shift once per tick and compare their new entry against
// fold_threshold in parallel. One tick is accepted per cycle; an output
// register decouples the two sides, so a new tick is taken while a result
// waits as long as that result is taken in the same cycle. A retract is
// issued when all window entries exceed fold_threshold, the threshold is
// nonzero, used_as_shutter is 0, and at least 30 ticks have passed since
// the last command. Write configuration only while no tick is in flight.
module wind_gust_retract_guard
  import wgrg_pkg::*;
#(
  parameter int WINDOW_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pulse_count,
  input  logic        din_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  wind_speed,
  output logic        retract_command,
  output logic        all_above,
  output logic        din_state
);

  speed_t     fold_threshold;
  logic       used_as_shutter;
  holdoff_t   holdoff;
  holdoff_t   holdoff_next;
  holdoff_t   holdoff_inc;
  speed_t     speed_new;
  logic       enabled;
  logic       command;
  logic       transfer;
  cell_ctrl_t ctrl;

  speed_t     cell_speed [WINDOW_LEN];
  speed_t     cell_in    [WINDOW_LEN];
  logic       cell_above [WINDOW_LEN+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_threshold  <= '0;
      used_as_shutter <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOLD_THRESHOLD:  fold_threshold  <= cfg_data;
        REG_USED_AS_SHUTTER: used_as_shutter <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign transfer = in_valid && in_ready;

  assign speed_new = (pulse_count[15:1] > 15'(SPEED_MAX)) ? SPEED_MAX : pulse_count[8:1];

  assign ctrl.advance   = transfer;
  assign ctrl.threshold = fold_threshold;

  assign cell_above[WINDOW_LEN] = 1'b1;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == WINDOW_LEN - 1) begin : g_tail
      assign cell_in[i] = speed_new;
    end else begin : g_body
      assign cell_in[i] = cell_speed[i+1];
    end

    wgrg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .speed_in  (cell_in[i]),
      .above_in  (cell_above[i+1]),
      .speed_out (cell_speed[i]),
      .above_out (cell_above[i])
    );
  end

  assign enabled     = !used_as_shutter && (fold_threshold != '0);
  assign holdoff_inc = (holdoff != HOLDOFF_MAX) ? holdoff + 5'd1 : holdoff;
  assign command     = enabled && cell_above[0] && (holdoff_inc >= HOLDOFF_PERIOD);

  always_comb begin
    if (!enabled) begin
      holdoff_next = HOLDOFF_PERIOD;
    end else if (command) begin
      holdoff_next = '0;
    end else begin
      holdoff_next = holdoff_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff   <= HOLDOFF_PERIOD;
      out_valid <= 1'b0;
    end else begin
      if (transfer) begin
        holdoff <= holdoff_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (transfer) begin
      wind_speed      <= speed_new;
      retract_command <= command;
      all_above       <= cell_above[0];
      din_state       <= din_level;
    end
  end

  a_cmd_needs_above: assert property (@(posedge clk) disable iff (rst)
    out_valid && retract_command |-> all_above)
    else $error("retract issued without full window above threshold");

  a_cmd_clears_holdoff: assert property (@(posedge clk) disable iff (rst)
    transfer && command |=> holdoff == '0)
    else $error("holdoff not cleared after retract");

  a_disabled_holdoff: assert property (@(posedge clk) disable iff (rst)
    transfer && !enabled |=> holdoff == HOLDOFF_PERIOD)
    else $error("holdoff not parked while disabled");

  a_cmd_spacing: assert property (@(posedge clk) disable iff (rst)
    transfer && command |=> !(transfer && command))
    else $error("retract commands on consecutive ticks");

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wgrg_pkg::*;

  localparam int WINDOW_LEN = 4;

  typedef struct packed {
    speed_t speed;
    logic   retract;
    logic   above;
    logic   din;
  } tick_result_t;

  class retract_scoreboard;
    speed_t       threshold;
    logic         shutter;
    speed_t       window [WINDOW_LEN];
    holdoff_t     holdoff;
    tick_result_t expected_ticks [$];
    int           failures;

    function new();
      threshold = '0;
      shutter   = 1'b0;
      foreach (window[i]) window[i] = '0;
      holdoff   = HOLDOFF_PERIOD;
      failures  = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [7:0] data);
      case (idx)
        REG_FOLD_THRESHOLD: threshold = data;
        REG_USED_AS_SHUTTER: shutter = data[0];
        default: ;
      endcase
    endfunction

    function void predict_tick(logic [15:0] pulses, logic level);
      tick_result_t r;
      speed_t       spd;
      logic         above;
      logic         cmd;
      if (holdoff <= HOLDOFF_PERIOD) holdoff = holdoff + 1'b1;
      spd = ((pulses >> 1) > 16'(SPEED_MAX)) ? SPEED_MAX : pulses[8:1];
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i + 1];
      window[WINDOW_LEN - 1] = spd;
      above = 1'b1;
      foreach (window[i]) if (window[i] <= threshold) above = 1'b0;
      cmd = 1'b0;
      if (!shutter && threshold != '0) begin
        if (above && holdoff >= HOLDOFF_PERIOD) begin
          cmd = 1'b1;
          holdoff = '0;
        end
      end else begin
        holdoff = HOLDOFF_PERIOD;
      end
      r.speed   = spd;
      r.retract = cmd;
      r.above   = above;
      r.din     = level;
      expected_ticks.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("ERROR %0t: %s", $time, msg);
    endfunction

    function void check_result(tick_result_t act);
      tick_result_t exp;
      if (expected_ticks.size() == 0) begin
        flag($sformatf("unexpected result speed=%0d retract=%0b above=%0b din=%0b",
                       act.speed, act.retract, act.above, act.din));
        return;
      end
      exp = expected_ticks.pop_front();
      if (act.speed !== exp.speed || act.retract !== exp.retract ||
          act.above !== exp.above || act.din !== exp.din)
        flag($sformatf("exp speed=%0d retract=%0b above=%0b din=%0b, got %0d %0b %0b %0b",
                       exp.speed, exp.retract, exp.above, exp.din,
                       act.speed, act.retract, act.above, act.din));
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void close();
      if (expected_ticks.size() != 0)
        flag($sformatf("%0d results never arrived", expected_ticks.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] pulse_count;
  logic        din_level;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  wind_speed;
  logic        retract_command;
  logic        all_above;
  logic        din_state;

  retract_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;

  wind_gust_retract_guard #(.WINDOW_LEN(WINDOW_LEN)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pulse_count(pulse_count),
    .din_level(din_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .wind_speed(wind_speed),
    .retract_command(retract_command),
    .all_above(all_above),
    .din_state(din_state)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.predict_tick(pulse_count, din_level);
      if (out_valid && out_ready)
        sb.check_result({wind_speed, retract_command, all_above, din_state});
    end
  end

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [15:0] pulses, input logic level);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pulse_count <= pulses;
    din_level   <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] thr, input logic [7:0] shut);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FOLD_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    sb.set_register(REG_FOLD_THRESHOLD, thr);
    cfg_index <= REG_USED_AS_SHUTTER;
    cfg_data  <= shut;
    @(posedge clk);
    sb.set_register(REG_USED_AS_SHUTTER, shut);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] gust_pulses(input logic [7:0] thr);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      s = int'(thr) + int'($urandom_range(0, 8)) - 3;
      if (s < 0) s = 0;
      return 16'(s * 2 + int'($urandom_range(0, 1)));
    end
    if (r < 85) return 16'($urandom);
    return 16'($urandom_range(0, 511));
  endfunction

  initial begin
    logic [7:0] thr;
    logic       shut;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_FOLD_THRESHOLD;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    pulse_count <= '0;
    din_level   <= 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick(16'hFFFF, 1'b1);
    send_tick(16'h0000, 1'b0);
    send_tick(16'h0001, 1'b1);
    send_tick(16'h0002, 1'b0);
    send_tick(16'd399, 1'b1);
    send_tick(16'd400, 1'b0);
    send_tick(16'd401, 1'b1);
    send_tick(16'd402, 1'b0);
    send_tick(16'h5555, 1'b1);
    send_tick(16'hAAAA, 1'b0);
    wait_for_results();

    configure(8'd199, 8'hFF);
    repeat (4) send_tick(16'd400, 1'b1);
    wait_for_results();

    configure(8'd199, 8'hFE);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'd398, 1'b0);
    send_tick(16'd399, 1'b1);
    repeat (3) send_tick(16'd400, 1'b0);
    wait_for_results();

    configure(8'd255, 8'h00);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'h8000, 1'b0);
    wait_for_results();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: thr = 8'd0;
        1: thr = 8'd255;
        2: thr = 8'd1;
        3: thr = 8'd200;
        default: thr = 8'($urandom_range(1, 199));
      endcase
      shut = (phase % 5 == 4);
      configure(thr, {7'($urandom), shut});
      in_idle_pct  = (phase < 11) ? $urandom_range(0, 30) : 0;
      out_idle_pct = (phase < 11) ? $urandom_range(0, 30) : 0;
      for (int n = 0; n < 103; n++) begin
        send_tick(gust_pulses(thr), 1'($urandom));
        if (phase == 6 && n == 50) wait_for_results();
      end
      wait_for_results();
    end

    repeat (4) @(posedge clk);
    sb.close();
    if (sb.failures == 0) begin
      $display("wind_gust_retract_guard regression: pass");
    end else begin
      $display("wind_gust_retract_guard regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("wind_gust_retract_guard regression: fail");
    $finish;
  end

endmodule

// ----- wind_gust_retract_guard.f -----
src/wgrg_pkg.sv
src/wgrg_cell.sv
src/wind_gust_retract_guard.sv
test/tb.sv
